FILE: rtl/light_grid_trilinear_sampler_top_defines.svh
// Assertion macros for the light grid sampler.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef LIGHT_GRID_TRILINEAR_SAMPLER_TOP_DEFINES_SVH
`define LIGHT_GRID_TRILINEAR_SAMPLER_TOP_DEFINES_SVH

// General form with an explicit clock and active-low reset.
`define LGTS_ASSERT_CLK(clk, rst_n, lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form for modules clocked by clk_i with reset rst_ni.
`define LGTS_ASSERT(lbl, prop, msg) `LGTS_ASSERT_CLK(clk_i, rst_ni, lbl, prop, msg)

`endif

FILE: rtl/lgts_pkg.sv
// Shared constants, codes and payload types for the light grid sampler.
// No dependencies.
package lgts_pkg;

  localparam int GRID_ENTRIES = 16384;
  localparam int GRID_AW      = $clog2(GRID_ENTRIES);
  localparam int ENTRY_W      = 64;

  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] CFG_CELL_SIZE = 3'd3;
  localparam logic [2:0] CFG_ROW_LEN   = 3'd4;
  localparam logic [2:0] CFG_PLANE     = 3'd5;
  localparam logic [2:0] CFG_COUNT     = 3'd6;

  localparam logic [1:0] ST_SAMPLED = 2'd0;
  localparam logic [1:0] ST_NOGRID  = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  localparam logic [15:0] NOGRID_AMBIENT  = 16'h4000;
  localparam logic [15:0] NOGRID_DIFFUSE  = 16'hC000;
  localparam logic [15:0] OUTSIDE_AMBIENT = 16'hFF00;

  localparam logic [35:0] CELL_SIZE_RESET = 36'h080040040;

  typedef struct packed {
    logic               mode;
    logic [13:0]        entry_index;
    logic [23:0]        entry_ambient;
    logic [23:0]        entry_diffuse;
    logic [15:0]        entry_direction;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] ambient_r;
    logic [15:0] ambient_g;
    logic [15:0] ambient_b;
    logic [15:0] diffuse_r;
    logic [15:0] diffuse_g;
    logic [15:0] diffuse_b;
    logic [15:0] dir_first;
    logic [15:0] dir_second;
  } out_t;

endpackage

FILE: rtl/lgts_in_if.sv
// Input channel of the light grid sampler: valid, ready and one item.
// Depends on lgts_pkg.
interface lgts_in_if;
  import lgts_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lgts_out_if.sv
// Output channel of the light grid sampler: valid, ready and one result.
// Depends on lgts_pkg.
interface lgts_out_if;
  import lgts_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lgts_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module lgts_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

FILE: rtl/light_grid_trilinear_sampler_top.sv
// Light grid sampler top level: register file, sequencer, shared divider and blend.
// Depends on lgts_pkg, lgts_in_if, lgts_out_if, lgts_ram and the defines header.
//
//  channel  | dir | beat
//  ---------+-----+-------------------------------------------
//  in_ch    | in  | write an entry (mode 0) or sample a point
//  out_ch   | out | one result beat per input beat
//  cfg      | in  | cfg_we_i / cfg_idx_i / cfg_data_i, no stall
//
// A write beat goes straight to done. A sample runs the one-bit restoring divider per axis
// (21 quotient steps, 8 fraction steps, load and sign fix), then 2 index multiplies, a range
// check, read, weight and accumulate per neighbour on the single store port, and done. Early
// outcomes (no grid, zero cell size) go straight to done; a point outside the map ends after
// the range check. The next beat is taken while a finished result waits in the output
// register; a result that is not taken holds the block in its done state. No store clear.
`include "light_grid_trilinear_sampler_top_defines.svh"
module light_grid_trilinear_sampler_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [35:0]          cfg_data_i,
  lgts_in_if.sink              in_ch,
  lgts_out_if.source           out_ch
);
  import lgts_pkg::*;

  localparam int IW = 36;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DLOAD = 4'd1;
  localparam logic [3:0] S_DSTEP = 4'd2;
  localparam logic [3:0] S_DFIX  = 4'd3;
  localparam logic [3:0] S_FSTEP = 4'd4;
  localparam logic [3:0] S_MUL0  = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_WT    = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  // configuration
  logic signed [19:0] org_q [3];
  logic [35:0]        cell_q;
  logic [14:0]        row_q, plane_q, count_q;

  // control
  logic [3:0] state_q;
  logic [1:0] ax_q;
  logic [4:0] cnt_q;
  logic [2:0] k_q;
  logic       out_valid_q;

  // datapath
  logic signed [19:0] pt_q [3];
  logic [1:0]         status_q;
  logic [20:0]        dvd_q;
  logic [15:0]        rem_q;
  logic               neg_q;
  logic signed [17:0] vi_q [3];
  logic [7:0]         frac_q [3];
  logic signed [IW-1:0] prod_q, idx0_q;
  logic [GRID_AW-1:0] idx_q [8];
  logic [17:0]        wxy_q;
  logic [24:0]        w_q;
  logic [31:0]        acc_q [8];
  out_t               out_q;
  out_t               out_d;

  logic accept;
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  // per-axis divisor and offset
  logic [11:0]        size_ax;
  logic [15:0]        div_s;
  logic signed [20:0] d_ax;
  always_comb begin
    size_ax = cell_q[11:0];
    case (ax_q)
      2'd0:    size_ax = cell_q[11:0];
      2'd1:    size_ax = cell_q[23:12];
      2'd2:    size_ax = cell_q[35:24];
      default: size_ax = cell_q[11:0];
    endcase
    div_s = {size_ax, 4'b0000};
    d_ax  = $signed({pt_q[ax_q][19], pt_q[ax_q]}) - $signed({org_q[ax_q][19], org_q[ax_q]});
  end

  // one restoring division step
  logic [16:0] rem_sh;
  logic        step_ge;
  logic [15:0] rem_nx;
  logic [20:0] dvd_nx;
  assign rem_sh  = {rem_q, dvd_q[20]};
  assign step_ge = rem_sh >= {1'b0, div_s};
  assign rem_nx  = step_ge ? 16'(rem_sh - {1'b0, div_s}) : rem_sh[15:0];
  assign dvd_nx  = {dvd_q[19:0], step_ge};

  // quotient sign fix and floor remainder
  logic signed [17:0] vi_fix;
  logic [15:0]        rr_fix;
  assign vi_fix = neg_q ? -$signed({1'b0, dvd_q[16:0]}) : $signed({1'b0, dvd_q[16:0]});
  assign rr_fix = (neg_q && rem_q != 16'd0) ? 16'(div_s - rem_q) : rem_q;

  // shared index multiplier
  logic signed [17:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [33:0] mul_p;
  assign mul_a = (state_q == S_MUL0) ? vi_q[2] : vi_q[1];
  assign mul_b = (state_q == S_MUL0) ? $signed({1'b0, plane_q}) : $signed({1'b0, row_q});
  assign mul_p = mul_a * mul_b;

  // eight neighbour indices and range check
  logic signed [IW-1:0] idx_c [8];
  logic signed [IW-1:0] row_s, plane_s, cnt_s, cntm1_s, grid_s;
  logic                 any_bad;
  always_comb begin
    row_s   = $signed(IW'(row_q));
    plane_s = $signed(IW'(plane_q));
    cnt_s   = $signed(IW'(count_q));
    cntm1_s = cnt_s - IW'(1);
    grid_s  = $signed(IW'(GRID_ENTRIES));
    idx_c[0] = idx0_q;
    idx_c[1] = idx0_q + row_s;
    idx_c[2] = idx0_q + plane_s;
    idx_c[3] = idx_c[2] + row_s;
    for (int i = 0; i < 4; i++) begin
      idx_c[i+4] = idx_c[i] + ((idx_c[i] < cntm1_s) ? IW'(1) : IW'(0));
    end
    any_bad = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (idx_c[i] < 0 || idx_c[i] >= cnt_s || idx_c[i] >= grid_s) begin
        any_bad = 1'b1;
      end
    end
  end

  // weights for neighbour k: bit 0 picks fx, bit 1 fy, bit 2 fz
  logic [8:0] wx, wy, wz;
  assign wx = k_q[0] ? {1'b0, frac_q[0]} : 9'(9'd256 - frac_q[0]);
  assign wy = k_q[1] ? {1'b0, frac_q[1]} : 9'(9'd256 - frac_q[1]);
  assign wz = k_q[2] ? {1'b0, frac_q[2]} : 9'(9'd256 - frac_q[2]);

  // store port
  logic               ram_we;
  logic [GRID_AW-1:0] ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  assign ram_we    = accept && !in_ch.data.mode &&
                     (32'(in_ch.data.entry_index) < 32'(GRID_ENTRIES));
  assign ram_addr  = (state_q == S_IDLE) ? GRID_AW'(in_ch.data.entry_index)
                                         : idx_q[{k_q[0], k_q[2:1]}];
  assign ram_wdata = {in_ch.data.entry_direction, in_ch.data.entry_diffuse,
                      in_ch.data.entry_ambient};

  lgts_ram #(.WIDTH(ENTRY_W), .DEPTH(GRID_ENTRIES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic out_load;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);

  // result beat assembled from the status and the accumulators
  always_comb begin
    out_d        = '0;
    out_d.status = status_q;
    case (status_q)
      ST_SAMPLED: begin
        out_d.ambient_r  = acc_q[0][31:16];
        out_d.ambient_g  = acc_q[1][31:16];
        out_d.ambient_b  = acc_q[2][31:16];
        out_d.diffuse_r  = acc_q[3][31:16];
        out_d.diffuse_g  = acc_q[4][31:16];
        out_d.diffuse_b  = acc_q[5][31:16];
        out_d.dir_first  = acc_q[6][31:16];
        out_d.dir_second = acc_q[7][31:16];
      end
      ST_NOGRID: begin
        out_d.ambient_r = NOGRID_AMBIENT;
        out_d.ambient_g = NOGRID_AMBIENT;
        out_d.ambient_b = NOGRID_AMBIENT;
        out_d.diffuse_r = NOGRID_DIFFUSE;
        out_d.diffuse_g = NOGRID_DIFFUSE;
        out_d.diffuse_b = NOGRID_DIFFUSE;
      end
      ST_OUTSIDE: begin
        out_d.ambient_r = OUTSIDE_AMBIENT;
        out_d.ambient_g = OUTSIDE_AMBIENT;
        out_d.ambient_b = OUTSIDE_AMBIENT;
      end
      default: ;
    endcase
  end

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0]    <= '0;
      org_q[1]    <= '0;
      org_q[2]    <= '0;
      cell_q      <= CELL_SIZE_RESET;
      row_q       <= 15'd1;
      plane_q     <= 15'd1;
      count_q     <= '0;
      state_q     <= S_IDLE;
      ax_q        <= '0;
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ORIGIN_X:  org_q[0] <= cfg_data_i[19:0];
          CFG_ORIGIN_Y:  org_q[1] <= cfg_data_i[19:0];
          CFG_ORIGIN_Z:  org_q[2] <= cfg_data_i[19:0];
          CFG_CELL_SIZE: cell_q   <= cfg_data_i;
          CFG_ROW_LEN:   row_q    <= cfg_data_i[14:0];
          CFG_PLANE:     plane_q  <= cfg_data_i[14:0];
          CFG_COUNT:     count_q  <= cfg_data_i[14:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            ax_q <= '0;
            if (!in_ch.data.mode || count_q == 15'd0 || cell_q[11:0] == 12'd0 ||
                cell_q[23:12] == 12'd0 || cell_q[35:24] == 12'd0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_DLOAD;
            end
          end
        end
        S_DLOAD: begin
          cnt_q   <= '0;
          state_q <= S_DSTEP;
        end
        S_DSTEP: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd20) begin
            state_q <= S_DFIX;
          end
        end
        S_DFIX: begin
          cnt_q   <= '0;
          state_q <= S_FSTEP;
        end
        S_FSTEP: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd7) begin
            if (ax_q == 2'd2) begin
              state_q <= S_MUL0;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= S_DLOAD;
            end
          end
        end
        S_MUL0:  state_q <= S_MUL1;
        S_MUL1:  state_q <= S_CHECK;
        S_CHECK: begin
          k_q     <= '0;
          state_q <= any_bad ? S_DONE : S_RD;
        end
        S_RD:    state_q <= S_WT;
        S_WT:    state_q <= S_ACC;
        S_ACC: begin
          k_q     <= k_q + 3'd1;
          state_q <= (k_q == 3'd7) ? S_DONE : S_RD;
        end
        S_DONE: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          pt_q[0] <= in_ch.data.point_x;
          pt_q[1] <= in_ch.data.point_y;
          pt_q[2] <= in_ch.data.point_z;
          if (!in_ch.data.mode) begin
            status_q <= ST_WRITTEN;
          end else if (count_q == 15'd0) begin
            status_q <= ST_NOGRID;
          end else begin
            status_q <= ST_OUTSIDE;
          end
        end
      end
      S_DLOAD: begin
        neg_q <= d_ax[20];
        dvd_q <= d_ax[20] ? 21'(-d_ax) : 21'(d_ax);
        rem_q <= '0;
      end
      S_DSTEP, S_FSTEP: begin
        rem_q <= rem_nx;
        dvd_q <= dvd_nx;
        if (state_q == S_FSTEP && cnt_q == 5'd7) begin
          frac_q[ax_q] <= dvd_nx[7:0];
        end
      end
      S_DFIX: begin
        vi_q[ax_q] <= vi_fix;
        rem_q      <= rr_fix;
        dvd_q      <= '0;
      end
      S_MUL0: prod_q <= IW'(mul_p);
      S_MUL1: idx0_q <= prod_q + IW'(mul_p) + IW'(vi_q[0]);
      S_CHECK: begin
        if (!any_bad) begin
          status_q <= ST_SAMPLED;
        end
        for (int i = 0; i < 8; i++) begin
          idx_q[i] <= idx_c[i][GRID_AW-1:0];
          acc_q[i] <= '0;
        end
      end
      S_RD: wxy_q <= wx * wy;
      S_WT: w_q   <= 25'(wxy_q) * 25'(wz);
      S_ACC: begin
        for (int i = 0; i < 8; i++) begin
          acc_q[i] <= acc_q[i] + 32'(w_q) * 32'(ram_rdata[8*i +: 8]);
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Stores happen only on an accepted write beat.
  `LGTS_ASSERT(a_store_write_idle, ram_we |-> (state_q == S_IDLE && accept), "store write outside idle")
  // A sample that passes the early checks enters the divider next.
  `LGTS_ASSERT(a_sample_divides, (accept && in_ch.data.mode && state_q == S_IDLE && count_q != 15'd0 && cell_q[11:0] != 12'd0 && cell_q[23:12] != 12'd0 && cell_q[35:24] != 12'd0) |=> state_q == S_DLOAD, "sample skipped divider")
  // The neighbour counter holds during the read and weight states.
  `LGTS_ASSERT(a_k_stable, (state_q == S_RD || state_q == S_WT) |=> $stable(k_q), "neighbour counter moved")
  // A result register load in the done state is followed by a valid result and the idle state.
  `LGTS_ASSERT(a_load_done, out_load |=> (out_valid_q && state_q == S_IDLE), "result load lost")
endmodule

FILE: dv/tb_light_grid_trilinear_sampler_top.sv
// Self-checking testbench for light_grid_trilinear_sampler_top: loads grid entries,
// samples points and compares every result beat with a local trilinear predictor.
// Depends on lgts_pkg, lgts_in_if, lgts_out_if and the RTL of the block.
module tb_light_grid_trilinear_sampler_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lgts_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [35:0] cfg_data_i;

  lgts_in_if  in_ch ();
  lgts_out_if out_ch ();

  light_grid_trilinear_sampler_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predictor copy of the register file and the grid store.
  logic signed [19:0] org_x, org_y, org_z;
  logic [35:0]        cell_sz;
  logic [14:0]        row_len, plane_len, elem_count;
  logic [63:0]        grid_mem [GRID_ENTRIES];
  bit                 grid_written [GRID_ENTRIES];

  in_t  pending_beats[$];
  out_t expected_results[$];
  int   fail_cnt;
  bit   src_idle_en;
  bit   snk_idle_en;
  bit   hold_go;
  bit   hold_done;
  int   hold_cnt;
  int   src_gap;

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    fail_cnt++;
  endtask

  function automatic void fill_result(output out_t r, input logic [1:0] st,
                                      input logic [15:0] amb, input logic [15:0] dif);
    r = '0;
    r.status    = st;
    r.ambient_r = amb;
    r.ambient_g = amb;
    r.ambient_b = amb;
    r.diffuse_r = dif;
    r.diffuse_g = dif;
    r.diffuse_b = dif;
  endfunction

  // Works out the result of one beat; blank_read flags a read of an unwritten entry.
  function automatic void predict_light(input in_t it, output out_t r, output bit blank_read);
    longint pt[3], org[3], vi[3], nb[8];
    longint d, s, rem, sz, cnt;
    longint unsigned fr[3], wt[8], acc[8], e, wx, wy, wz;
    int a, k, i;
    blank_read = 1'b0;
    if (!it.mode) begin
      fill_result(r, ST_WRITTEN, '0, '0);
      return;
    end
    if (elem_count == 0) begin
      fill_result(r, ST_NOGRID, NOGRID_AMBIENT, NOGRID_DIFFUSE);
      return;
    end
    pt[0] = it.point_x;
    pt[1] = it.point_y;
    pt[2] = it.point_z;
    org[0] = org_x;
    org[1] = org_y;
    org[2] = org_z;
    for (a = 0; a < 3; a++) begin
      sz = (cell_sz >> (12 * a)) & 36'hFFF;
      if (sz == 0) begin
        fill_result(r, ST_OUTSIDE, OUTSIDE_AMBIENT, '0);
        return;
      end
      s = sz * 16;
      d = pt[a] - org[a];
      vi[a] = d / s;
      rem = d % s;
      if (rem < 0) rem += s;
      fr[a] = (rem * 256) / s;
    end
    cnt = elem_count;
    nb[0] = vi[2] * longint'(plane_len) + vi[1] * longint'(row_len) + vi[0];
    nb[1] = nb[0] + row_len;
    nb[2] = nb[0] + plane_len;
    nb[3] = nb[2] + row_len;
    for (i = 0; i < 4; i++) nb[i + 4] = nb[i] + ((nb[i] < cnt - 1) ? 1 : 0);
    for (i = 0; i < 8; i++) begin
      if (nb[i] < 0 || nb[i] >= cnt || nb[i] >= GRID_ENTRIES) begin
        fill_result(r, ST_OUTSIDE, OUTSIDE_AMBIENT, '0);
        return;
      end
    end
    for (i = 0; i < 8; i++) acc[i] = 0;
    for (k = 0; k < 8; k++) begin
      wx = (k & 1) ? fr[0] : 256 - fr[0];
      wy = (k & 2) ? fr[1] : 256 - fr[1];
      wz = (k & 4) ? fr[2] : 256 - fr[2];
      wt[k] = wx * wy * wz;
      if (!grid_written[nb[(k >> 1) + 4 * (k & 1)]]) blank_read = 1'b1;
      e = grid_mem[nb[(k >> 1) + 4 * (k & 1)]];
      for (i = 0; i < 8; i++) acc[i] += wt[k] * ((e >> (8 * i)) & 64'hFF);
    end
    r = '0;
    r.status     = ST_SAMPLED;
    r.ambient_r  = acc[0] >> 16;
    r.ambient_g  = acc[1] >> 16;
    r.ambient_b  = acc[2] >> 16;
    r.diffuse_r  = acc[3] >> 16;
    r.diffuse_g  = acc[4] >> 16;
    r.diffuse_b  = acc[5] >> 16;
    r.dir_first  = acc[6] >> 16;
    r.dir_second = acc[7] >> 16;
  endfunction

  task automatic queue_beat(input in_t it);
    out_t r;
    bit   blank;
    predict_light(it, r, blank);
    if (!it.mode) begin
      grid_mem[it.entry_index]     = {it.entry_direction, it.entry_diffuse, it.entry_ambient};
      grid_written[it.entry_index] = 1'b1;
    end
    pending_beats.push_back(it);
    expected_results.push_back(r);
  endtask

  function automatic in_t random_beat(input bit mode);
    in_t it;
    it.mode            = mode;
    it.entry_index     = $urandom;
    it.entry_ambient   = $urandom;
    it.entry_diffuse   = $urandom;
    it.entry_direction = $urandom;
    it.point_x         = $urandom;
    it.point_y         = $urandom;
    it.point_z         = $urandom;
    return it;
  endfunction

  task automatic queue_write(input int idx);
    in_t it;
    it = random_beat(1'b0);
    it.entry_index = idx;
    queue_beat(it);
  endtask

  // Aims a sample at a cell that starts at a written entry; falls back to a write.
  task automatic queue_aimed_sample(input int span);
    in_t    it;
    out_t   r;
    bit     blank;
    longint base, ix, iy, iz, p[3], o[3], sz;
    int     tries, a;
    bit     fits;
    for (tries = 0; tries < 20; tries++) begin
      it = random_beat(1'b1);
      base = $urandom_range(span - 1, 0);
      iz = base / plane_len;
      iy = (base % plane_len) / row_len;
      ix = (base % plane_len) % row_len;
      o[0] = org_x;
      o[1] = org_y;
      o[2] = org_z;
      fits = 1'b1;
      for (a = 0; a < 3; a++) begin
        sz = ((cell_sz >> (12 * a)) & 36'hFFF) * 16;
        if (sz == 0) sz = 16;
        p[a] = o[a] + ((a == 0) ? ix : (a == 1) ? iy : iz) * sz;
        // Small negative offsets truncate toward zero but keep a positive fraction.
        if ($urandom_range(9, 0) == 0) p[a] -= $urandom_range(sz - 1, 1);
        else p[a] += $urandom_range(sz - 1, 0);
        if (p[a] < -524288 || p[a] > 524287) fits = 1'b0;
      end
      if (fits) begin
        it.point_x = p[0];
        it.point_y = p[1];
        it.point_z = p[2];
        predict_light(it, r, blank);
        if (!blank) begin
          queue_beat(it);
          return;
        end
      end
    end
    queue_write($urandom_range(span - 1, 0));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [35:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_beats.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic signed [19:0] ox, input logic signed [19:0] oy,
                           input logic signed [19:0] oz, input logic [11:0] sx,
                           input logic [11:0] sy, input logic [11:0] sz,
                           input logic [14:0] rl, input logic [14:0] ps,
                           input logic [14:0] cnt, input int beats);
    in_t it;
    int  span, n, pick;
    wait_idle();
    src_idle_en = $urandom_range(3, 0) != 0;
    snk_idle_en = $urandom_range(3, 0) != 0;
    org_x = ox;
    org_y = oy;
    org_z = oz;
    cell_sz = {sz, sy, sx};
    row_len = rl;
    plane_len = ps;
    elem_count = cnt;
    write_reg(CFG_ORIGIN_X, {16'd0, ox});
    write_reg(CFG_ORIGIN_Y, {16'd0, oy});
    write_reg(CFG_ORIGIN_Z, {16'd0, oz});
    write_reg(CFG_CELL_SIZE, {sz, sy, sx});
    write_reg(CFG_ROW_LEN, {21'd0, rl});
    write_reg(CFG_PLANE, {21'd0, ps});
    write_reg(CFG_COUNT, {21'd0, cnt});
    span = (cnt == 0) ? 1 : ((cnt > 48) ? 48 : cnt);
    for (n = 0; n < span; n++) queue_write(n);
    for (n = 0; n < beats; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) begin
        it = random_beat(1'b0);
        if (pick < 5) it.entry_index = $urandom_range(span - 1, 0);
        queue_beat(it);
      end else if (pick < 18) begin
        it = random_beat(1'b1);
        if (elem_count == 0) queue_beat(it);
        else queue_aimed_sample(span);
        if (elem_count != 0) begin
          // Full-range noise: kept only when it stays clear of unwritten entries.
          out_t r;
          bit   blank;
          predict_light(it, r, blank);
          if (!blank) queue_beat(it);
        end
      end else begin
        queue_aimed_sample(span);
      end
    end
  endtask

  // Sender: one beat at a time from the pending queue, with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      src_gap     <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap > 0) begin
        in_ch.valid <= 1'b0;
        src_gap     <= src_gap - 1;
      end else if (pending_beats.size() != 0) begin
        in_ch.data  <= pending_beats.pop_front();
        in_ch.valid <= 1'b1;
        if (!src_idle_en || $urandom_range(9, 0) < 6) src_gap <= 0;
        else if ($urandom_range(9, 0) < 8) src_gap <= $urandom_range(3, 1);
        else src_gap <= $urandom_range(150, 20);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the block fills and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cnt  <= 600;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_cnt == 0) && (!snk_idle_en || $urandom_range(9, 0) < 7);
    end
  end

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Monitor: every accepted result beat against the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("status", 16'(out_ch.data.status), 16'(want.status));
        check_field("ambient_r", out_ch.data.ambient_r, want.ambient_r);
        check_field("ambient_g", out_ch.data.ambient_g, want.ambient_g);
        check_field("ambient_b", out_ch.data.ambient_b, want.ambient_b);
        check_field("diffuse_r", out_ch.data.diffuse_r, want.diffuse_r);
        check_field("diffuse_g", out_ch.data.diffuse_g, want.diffuse_g);
        check_field("diffuse_b", out_ch.data.diffuse_b, want.diffuse_b);
        check_field("dir_first", out_ch.data.dir_first, want.dir_first);
        check_field("dir_second", out_ch.data.dir_second, want.dir_second);
      end
    end
  end

  initial begin
    #20ms;
    $display("light_grid_trilinear_sampler_top: mismatch");
    $finish;
  end

  initial begin
    in_t it;
    int  n;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_ORIGIN_X;
    cfg_data_i  = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    fail_cnt    = 0;
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    hold_go     = 1'b0;
    org_x = '0;
    org_y = '0;
    org_z = '0;
    cell_sz    = CELL_SIZE_RESET;
    row_len    = 15'd1;
    plane_len  = 15'd1;
    elem_count = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed start on reset settings: field extremes and the no-grid answer.
    it = '0;
    it.entry_ambient   = '1;
    it.entry_diffuse   = '1;
    it.entry_direction = '1;
    queue_beat(it);
    it = '0;
    it.entry_index = GRID_ENTRIES - 1;
    queue_beat(it);
    it = '1;
    it.mode = 1'b0;
    queue_beat(it);
    it = '1;
    queue_beat(it);
    it = '0;
    it.mode    = 1'b1;
    it.point_x = -20'sd524288;
    it.point_y = 20'sd524287;
    it.point_z = -20'sd524288;
    queue_beat(it);
    for (n = 0; n < 10; n++) queue_beat(random_beat(n[0]));

    run_phase(0, 0, 0, 12'd1, 12'd1, 12'd1, 15'd4, 15'd16, 15'd48, 130);
    hold_go = 1'b1;
    run_phase(-20'sd524288, -20'sd524288, -20'sd524288, 12'd4095, 12'd4095, 12'd4095,
              15'd1, 15'd1, 15'd1, 110);
    run_phase(1000, -1000, 0, 12'd2, 12'd3, 12'd5, 15'd8, 15'd40, 15'd40, 130);
    run_phase(40, 40, 40, 12'd0, 12'd3, 12'd3, 15'd4, 15'd16, 15'd32, 60);
    run_phase(100, -200, 300, 12'd7, 12'd1, 12'd2, 15'd16384, 15'd16384, 15'd16384, 130);
    run_phase(0, 0, 0, 12'd64, 12'd64, 12'd128, 15'd6, 15'd30, 15'd30, 130);
    run_phase(20'sd524287, 20'sd524287, 20'sd524287, 12'd1, 12'd1, 12'd1,
              15'd2, 15'd4, 15'd8, 60);
    for (n = 0; n < 2; n++)
      run_phase($urandom_range(2000, 0) - 1000, $urandom_range(2000, 0) - 1000,
                $urandom_range(2000, 0) - 1000, $urandom_range(20, 1),
                $urandom_range(20, 1), $urandom_range(20, 1), 15'd4, 15'd12, 15'd36, 130);
    run_phase(0, 0, 0, 12'd3, 12'd3, 12'd3, 15'd3, 15'd9, 15'd0, 40);

    while (pending_beats.size() != 0 || expected_results.size() != 0 || in_ch.valid)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (expected_results.size() != 0) report_mismatch("expected results left over");
    if (fail_cnt == 0) begin
      $display("light_grid_trilinear_sampler_top: match");
    end else begin
      $display("light_grid_trilinear_sampler_top: mismatch");
    end
    $finish;
  end

endmodule
